// ===== src/ide_pkg.sv =====
package ide_pkg;

    localparam int DATA_W     = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 8;
    localparam int THR_W      = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;

    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
    localparam logic [THR_W-1:0] FALL_THR_RST = 8'h03;
    localparam logic [THR_W-1:0] RISE_THR_RST = 8'h09;

    typedef enum logic [1:0] {
        OP_SCAN     = 2'd0,
        OP_RD_RISE  = 2'd1,
        OP_RD_FALL  = 2'd2,
        OP_RD_STATE = 2'd3
    } t_op;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FALL_THR = 1'b0,
        REG_RISE_THR = 1'b1
    } t_reg;

    typedef struct packed {
        logic             scan;
        logic [THR_W-1:0] fall_thr;
        logic [THR_W-1:0] rise_thr;
    } t_lane_ctl;

    typedef struct packed {
        logic             accept;
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_merge_ctl;

endpackage

// ===== src/ide_lane.sv =====
module ide_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ide_pkg::t_lane_ctl i_ctl,
    input  logic               i_raw,
    output logic               o_deb,
    output logic               o_deb_next
);
    import ide_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_deb;
    logic             n_deb;
    logic [CNT_W-1:0] cnt_inc;
    logic [THR_W-1:0] thr;

    always_comb begin
        cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
        thr     = i_raw ? i_ctl.rise_thr : i_ctl.fall_thr;
        n_cnt   = r_cnt;
        n_deb   = r_deb;
        if (i_ctl.scan) begin
            if (i_raw != r_deb) begin
                n_cnt = cnt_inc;
                // A threshold of zero switches on the first disagreeing scan.
                if (cnt_inc >= thr) begin
                    n_deb = i_raw;
                end
            end else begin
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_deb <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_deb <= n_deb;
        end
    end

    assign o_deb      = r_deb;
    assign o_deb_next = n_deb;

endmodule

// ===== src/ide_merge.sv =====
module ide_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ide_pkg::t_merge_ctl         i_ctl,
    input  logic [ide_pkg::DATA_W-1:0]  i_deb,
    input  logic [ide_pkg::DATA_W-1:0]  i_deb_next,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    output logic [ide_pkg::DATA_W-1:0]  o_debounced,
    output logic                        o_query
);
    import ide_pkg::*;

    logic [DATA_W-1:0] r_rise;
    logic [DATA_W-1:0] n_rise;
    logic [DATA_W-1:0] r_fall;
    logic [DATA_W-1:0] n_fall;
    logic              r_valid;
    logic              n_valid;
    logic [DATA_W-1:0] r_out_deb;
    logic              r_q;
    logic              q;

    // Lanes that do not exist hold zero in every word, so their queries read 0.
    always_comb begin
        n_rise = r_rise;
        n_fall = r_fall;
        q      = 1'b0;
        if (i_ctl.accept) begin
            case (i_ctl.op)
                OP_SCAN: begin
                    n_rise = r_rise | (i_deb_next & ~i_deb);
                    n_fall = r_fall | (~i_deb_next & i_deb);
                end
                OP_RD_RISE: begin
                    q                 = r_rise[i_ctl.idx];
                    n_rise[i_ctl.idx] = 1'b0;
                end
                OP_RD_FALL: begin
                    q                 = r_fall[i_ctl.idx];
                    n_fall[i_ctl.idx] = 1'b0;
                end
                OP_RD_STATE: begin
                    q = i_deb[i_ctl.idx];
                end
                default: begin
                    q = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        if (i_ctl.accept) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise  <= '0;
            r_fall  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_out_deb <= i_deb_next;
            r_q       <= q;
        end
    end

    assign o_m_tvalid  = r_valid;
    assign o_debounced = r_out_deb;
    assign o_query     = r_q;

endmodule

// ===== src/input_debounce_edge_latch.sv =====
// Debounces up to 16 raw inputs and latches their edges as sticky event flags.
// Slave channel: tuser carries the operation (scan, read-clear rise flag,
// read-clear fall flag, read state); tdata carries the raw word for a scan
// and the input index for a query. Every item gives exactly one result on the
// master channel: the debounced word after the item and the queried bit.
// The result is registered when its item is accepted. One item is taken every
// cycle; the figure is set by the per-input counters, which all update side
// by side, and by the single output register. While the receiver stalls, the
// output register holds its result and the slave side keeps taking items
// only in a cycle in which that result is taken. The user must write the
// thresholds on the plain write port only while no item is in flight; the
// block itself does not enforce this. A synchronous low reset clears all
// counters, debounced bits and flags, empties the output register and loads
// the thresholds with their defaults of three (falling) and nine (rising).
module input_debounce_edge_latch #(
    parameter int NUM_INPUTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ide_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ide_pkg::THR_W-1:0]         i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [15:0] raw_inputs, [19:16] input_index, [23:20] zero
    input  logic [ide_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [1:0] operation
    input  logic [ide_pkg::S_TUSER_W-1:0]     i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [15:0] debounced_bits, [16] query_bit, [23:17] zero
    output logic [ide_pkg::M_TDATA_W-1:0]     o_m_tdata
);
    import ide_pkg::*;

    localparam int LANES = (NUM_INPUTS < DATA_W) ? NUM_INPUTS : DATA_W;

    logic [THR_W-1:0]  r_fall_thr;
    logic [THR_W-1:0]  r_rise_thr;
    logic              s_acc;
    t_op               op;
    logic [DATA_W-1:0] raw;
    logic [IDX_W-1:0]  idx;
    t_lane_ctl         lane_ctl;
    t_merge_ctl        merge_ctl;
    logic [DATA_W-1:0] deb;
    logic [DATA_W-1:0] deb_next;
    logic [DATA_W-1:0] out_deb;
    logic              out_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fall_thr <= FALL_THR_RST;
            r_rise_thr <= RISE_THR_RST;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_addr))
                REG_FALL_THR: r_fall_thr <= i_cfg_data;
                REG_RISE_THR: r_rise_thr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_s_tready = !o_m_tvalid || i_m_tready;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign op         = t_op'(i_s_tuser[1:0]);
    assign raw        = i_s_tdata[DATA_W-1:0];
    assign idx        = i_s_tdata[DATA_W+IDX_W-1:DATA_W];

    assign lane_ctl.scan     = s_acc && (op == OP_SCAN);
    assign lane_ctl.fall_thr = r_fall_thr;
    assign lane_ctl.rise_thr = r_rise_thr;

    assign merge_ctl.accept = s_acc;
    assign merge_ctl.op     = op;
    assign merge_ctl.idx    = idx;

    for (genvar g = 0; g < DATA_W; g++) begin : g_lane
        if (g < LANES) begin : g_on
            ide_lane u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (lane_ctl),
                .i_raw      (raw[g]),
                .o_deb      (deb[g]),
                .o_deb_next (deb_next[g])
            );
        end else begin : g_off
            assign deb[g]      = 1'b0;
            assign deb_next[g] = 1'b0;
        end
    end

    ide_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (merge_ctl),
        .i_deb       (deb),
        .i_deb_next  (deb_next),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_debounced (out_deb),
        .o_query     (out_q)
    );

    assign o_m_tdata = {{(M_TDATA_W-DATA_W-1){1'b0}}, out_q, out_deb};

`ifndef NO_ASSERTIONS
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> o_m_tvalid)
        else $error("accepted item produced no result");

    a_scan_query_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && op == OP_SCAN) |=> !out_q)
        else $error("scan result carries a nonzero query bit");

    a_query_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && op != OP_SCAN) |=> (deb == $past(deb)))
        else $error("query item changed the debounced state");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (out_deb == deb))
        else $error("result word differs from the debounced state");
`endif

endmodule

// ===== dv/tb_input_debounce_edge_latch.sv =====
`timescale 1ns / 1ps

module tb_input_debounce_edge_latch;
    import ide_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int LONG_HOLD  = 60;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [THR_W-1:0]      i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // [15:0] raw_inputs, [19:16] input_index, [23:20] zero
    logic [S_TDATA_W-1:0]  i_s_tdata  = '0;
    // [1:0] operation
    logic [S_TUSER_W-1:0]  i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [15:0] debounced_bits, [16] query_bit, [23:17] zero
    logic [M_TDATA_W-1:0]  o_m_tdata;

    input_debounce_edge_latch #(.NUM_INPUTS(16)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [DATA_W-1:0] deb;
        logic              q;
    } t_result;

    // One directed row: either a register write or an item, with an optional typed result.
    typedef struct packed {
        logic              wr;
        t_reg              reg_sel;
        logic [THR_W-1:0]  reg_val;
        t_op               op;
        logic [DATA_W-1:0] raw;
        logic [IDX_W-1:0]  idx;
        logic              chk;
        logic [DATA_W-1:0] deb;
        logic              q;
    } t_row;

    // Shadow copy of the block's state and thresholds.
    logic [THR_W-1:0]  fall_thr;
    logic [THR_W-1:0]  rise_thr;
    logic [DATA_W-1:0] deb_state;
    logic [DATA_W-1:0] prev_deb;
    logic [DATA_W-1:0] rise_fl;
    logic [DATA_W-1:0] fall_fl;
    logic [CNT_W-1:0]  disagree [DATA_W];

    t_result pending_results [$];

    int  n_items    = 0;
    int  n_results  = 0;
    int  n_err      = 0;
    int  n_settings = 0;
    int  idle_cycles = 0;
    bit  burst    = 1'b0;
    bit  hold_req = 1'b0;

    t_row dir_rows [0:21];

    function automatic t_result debounce_step(t_op op, logic [DATA_W-1:0] raw,
                                              logic [IDX_W-1:0] idx);
        t_result           res;
        logic [DATA_W-1:0] sel;
        logic [DATA_W-1:0] changes;
        logic [THR_W-1:0]  thr;
        sel   = 16'(1) << idx;
        res.q = 1'b0;
        case (op)
            OP_SCAN: begin
                for (int n = 0; n < DATA_W; n++) begin
                    if (raw[n] != deb_state[n]) begin
                        thr = raw[n] ? rise_thr : fall_thr;
                        if (disagree[n] != CNT_MAX) disagree[n] = disagree[n] + 1'b1;
                        if (disagree[n] >= thr) deb_state[n] = raw[n];
                    end else begin
                        disagree[n] = '0;
                    end
                end
                changes  = deb_state ^ prev_deb;
                rise_fl |= deb_state & changes;
                fall_fl |= ~deb_state & changes;
                prev_deb = deb_state;
            end
            OP_RD_RISE: begin
                res.q   = |(rise_fl & sel);
                rise_fl = rise_fl & ~sel;
            end
            OP_RD_FALL: begin
                res.q   = |(fall_fl & sel);
                fall_fl = fall_fl & ~sel;
            end
            default: begin
                res.q = |(deb_state & sel);
            end
        endcase
        res.deb = deb_state;
        return res;
    endfunction

    task automatic send_item(t_op op, logic [DATA_W-1:0] raw, logic [IDX_W-1:0] idx,
                             logic chk, t_result typed);
        int      gap;
        t_result res;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'b0, idx, raw};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        res = debounce_step(op, raw, idx);
        pending_results.push_back(chk ? typed : res);
        n_items++;
    endtask

    // Thresholds change only once every result is back and the pipeline is empty.
    task automatic write_reg(t_reg sel, logic [THR_W-1:0] val);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= sel;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (sel)
            REG_FALL_THR: fall_thr = val;
            REG_RISE_THR: rise_thr = val;
            default: ;
        endcase
    endtask

    // Mostly steady raw words with occasional bounces, target changes and noise,
    // interleaved with queries.
    task automatic run_phase(logic [THR_W-1:0] f_thr, logic [THR_W-1:0] r_thr, int n,
                             int q_pct, int bounce_pct, int chg_pct, int hold_at);
        logic [DATA_W-1:0] target;
        logic [DATA_W-1:0] raw;
        t_op               op;
        int                pick;
        write_reg(REG_FALL_THR, f_thr);
        write_reg(REG_RISE_THR, r_thr);
        n_settings++;
        target = 16'($urandom);
        for (int i = 0; i < n; i++) begin
            burst = (i % 97) < 15;
            if (i == hold_at) hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < q_pct) begin
                op  = t_op'($urandom_range(1, 3));
                raw = 16'($urandom);
            end else begin
                op = OP_SCAN;
                if ($urandom_range(0, 99) < chg_pct) begin
                    if ($urandom_range(0, 1) == 0) target = 16'($urandom);
                    else target = target ^ (16'(1) << $urandom_range(0, 15));
                end
                raw = target;
                pick = $urandom_range(0, 99);
                if (pick < 5) raw = 16'($urandom);
                else if (pick < 5 + bounce_pct)
                    raw = raw ^ (16'(1) << $urandom_range(0, 15));
            end
            send_item(op, raw, 4'($urandom), 1'b0, '0);
        end
        burst = 1'b0;
    endtask

    // Receiver: random stalls per result, one long hold-off on request.
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = burst ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: debounced_bits %h, query_bit %b",
                       o_m_tdata[15:0], o_m_tdata[16]);
                n_err++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[15:0] !== want.deb) begin
                    $error("debounced_bits: expected %h, actual %h", want.deb, o_m_tdata[15:0]);
                    n_err++;
                end
                if (o_m_tdata[16] !== want.q) begin
                    $error("query_bit: expected %b, actual %b", want.q, o_m_tdata[16]);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_row r;
        fall_thr  = FALL_THR_RST;
        rise_thr  = RISE_THR_RST;
        deb_state = '0;
        prev_deb  = '0;
        rise_fl   = '0;
        fall_fl   = '0;
        for (int n = 0; n < DATA_W; n++) disagree[n] = '0;

        // Reset values, threshold one, raw ignored on queries, read-clear,
        // threshold zero and then the largest falling threshold.
        dir_rows = '{
            '{1'b0, REG_FALL_THR, 8'h00, OP_RD_STATE, 16'hFFFF, 4'h0, 1'b1, 16'h0000, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_RD_RISE,  16'h0000, 4'hF, 1'b1, 16'h0000, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_RD_FALL,  16'h0000, 4'h0, 1'b1, 16'h0000, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_SCAN,     16'hFFFF, 4'hF, 1'b1, 16'h0000, 1'b0},
            '{1'b1, REG_FALL_THR, 8'h01, OP_SCAN,     16'h0000, 4'h0, 1'b0, 16'h0000, 1'b0},
            '{1'b1, REG_RISE_THR, 8'h01, OP_SCAN,     16'h0000, 4'h0, 1'b0, 16'h0000, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_SCAN,     16'hFFFF, 4'h0, 1'b1, 16'hFFFF, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_RD_RISE,  16'h0000, 4'h0, 1'b1, 16'hFFFF, 1'b1},
            '{1'b0, REG_FALL_THR, 8'h00, OP_RD_RISE,  16'h0000, 4'h0, 1'b1, 16'hFFFF, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_RD_STATE, 16'h0000, 4'hF, 1'b1, 16'hFFFF, 1'b1},
            '{1'b0, REG_FALL_THR, 8'h00, OP_SCAN,     16'h0000, 4'hF, 1'b1, 16'h0000, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_RD_FALL,  16'hFFFF, 4'hF, 1'b1, 16'h0000, 1'b1},
            '{1'b0, REG_FALL_THR, 8'h00, OP_RD_FALL,  16'h0000, 4'hF, 1'b1, 16'h0000, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_RD_RISE,  16'h0000, 4'h5, 1'b0, 16'h0000, 1'b0},
            '{1'b1, REG_FALL_THR, 8'h00, OP_SCAN,     16'h0000, 4'h0, 1'b0, 16'h0000, 1'b0},
            '{1'b1, REG_RISE_THR, 8'h00, OP_SCAN,     16'h0000, 4'h0, 1'b0, 16'h0000, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_SCAN,     16'hA5A5, 4'h0, 1'b0, 16'h0000, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_SCAN,     16'h5A5A, 4'h0, 1'b0, 16'h0000, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_RD_FALL,  16'h0000, 4'h0, 1'b0, 16'h0000, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_RD_STATE, 16'h0000, 4'h1, 1'b0, 16'h0000, 1'b0},
            '{1'b1, REG_FALL_THR, 8'hFF, OP_SCAN,     16'h0000, 4'h0, 1'b0, 16'h0000, 1'b0},
            '{1'b0, REG_FALL_THR, 8'h00, OP_SCAN,     16'hFFFF, 4'h0, 1'b0, 16'h0000, 1'b0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        n_settings = 3;
        for (int i = 0; i < $size(dir_rows); i++) begin
            r = dir_rows[i];
            if (r.wr) write_reg(r.reg_sel, r.reg_val);
            else send_item(r.op, r.raw, r.idx, r.chk, t_result'{r.deb, r.q});
        end

        run_phase(FALL_THR_RST, RISE_THR_RST, 200, 30, 15, 4, 50);
        run_phase(8'd1, 8'd1, 150, 35, 20, 8, -1);
        run_phase(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)), 200, 30, 10, 4, -1);
        run_phase(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)), 200, 25, 25, 6, -1);
        // A steady word needs 255 disagreeing scans in a row to switch here.
        run_phase(8'd255, 8'd255, 320, 10, 0, 0, -1);
        run_phase(8'd0, 8'd0, 100, 30, 20, 5, -1);
        run_phase(8'd1, 8'd255, 100, 30, 10, 5, -1);
        run_phase(8'd255, 8'd1, 100, 30, 10, 5, -1);

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);

        $display("Ran %0d items and checked %0d results over %0d threshold settings,",
                 n_items, n_results, n_settings);
        $display("including zero and 255 thresholds and a long receiver hold-off.");
        if (n_err == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== input_debounce_edge_latch.f =====
src/ide_pkg.sv
src/ide_lane.sv
src/ide_merge.sv
src/input_debounce_edge_latch.sv
dv/tb_input_debounce_edge_latch.sv
